FILE: hw/rtl/rv_pkg.sv
// Shared types and constants for the refraction direction core.
// Used by every module under hw/rtl; depends on nothing else.

package rv_pkg;

    // Data width of the Q2.14 fields.
    localparam int DataW       = 16;
    // Root bits of floor(sqrt(1 - sin2t)) in Q28; 1.0 needs bit 28.
    localparam int SqrtBits    = 29;
    // Radicand 2^56 - sin2t, at most 2^56.
    localparam int RadW        = 57;
    // Trial subtrahend of one root step, with headroom above the radicand.
    localparam int TrialW      = RadW + 2;
    localparam int FrontStages = 6;
    localparam int BackStages  = 3;
    localparam int Latency     = FrontStages + SqrtBits + BackStages;

    // Data that rides alongside the radicand through the root pipeline.
    typedef struct packed {
        logic               tir;
        logic signed [35:0] eta_cos;
        logic signed [32:0] ew_x;
        logic signed [32:0] ew_y;
        logic signed [32:0] ew_z;
        logic signed [15:0] n_x;
        logic signed [15:0] n_y;
        logic signed [15:0] n_z;
    } t_side;

endpackage

FILE: hw/rtl/rv_front.sv
// Front stages of the refraction core: dot product, cosine, sin2t and the
// total internal reflection test. Depends on rv_pkg.

module rv_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic signed [rv_pkg::DataW-1:0]  i_wx,
    input  logic signed [rv_pkg::DataW-1:0]  i_wy,
    input  logic signed [rv_pkg::DataW-1:0]  i_wz,
    input  logic signed [rv_pkg::DataW-1:0]  i_nx,
    input  logic signed [rv_pkg::DataW-1:0]  i_ny,
    input  logic signed [rv_pkg::DataW-1:0]  i_nz,
    input  logic        [rv_pkg::DataW-1:0]  i_eta,
    output logic                             o_vld,
    output logic        [rv_pkg::RadW-1:0]   o_rad,
    output rv_pkg::t_side                    o_side
);

    // Stage 1: all products that need only the inputs.
    logic               r_v1;
    logic signed [31:0] r_p0, r_p1, r_p2;
    logic        [31:0] r_eta2;
    logic        [15:0] r_eta1;
    logic signed [32:0] r_ewx1, r_ewy1, r_ewz1;
    logic signed [15:0] r_nx1, r_ny1, r_nz1;

    // Stage 2: rounded cosine.
    logic               r_v2;
    logic signed [18:0] r_cos;
    logic        [31:0] r_eta2_2;
    logic        [15:0] r_eta2s;
    logic signed [32:0] r_ewx2, r_ewy2, r_ewz2;
    logic signed [15:0] r_nx2, r_ny2, r_nz2;

    // Stage 3: cos^2 and eta*cos.
    logic               r_v3;
    logic signed [37:0] r_cos2;
    logic        [31:0] r_eta2_3;
    rv_pkg::t_side      r_sd3;

    // Stage 4: sin2i.
    logic               r_v4;
    logic        [28:0] r_sin2i;
    logic        [31:0] r_eta2_4;
    rv_pkg::t_side      r_sd4;

    // Stage 5: sin2t.
    logic               r_v5;
    logic        [60:0] r_sin2t;
    rv_pkg::t_side      r_sd5;

    // Stage 6: radicand and reflection flag.
    logic               r_v6;
    logic        [rv_pkg::RadW-1:0] r_rad;
    rv_pkg::t_side      r_sd6;

    logic signed [16:0] w_eta_s1;
    logic signed [16:0] w_eta_s2;
    logic signed [32:0] w_dot;
    logic signed [37:0] w_cos2;
    logic signed [35:0] w_eta_cos;
    logic        [28:0] w_sin2i;
    rv_pkg::t_side      w_sd3;
    rv_pkg::t_side      w_sd6;

    assign w_eta_s1 = $signed({1'b0, i_eta});
    assign w_eta_s2 = $signed({1'b0, r_eta2s});

    // Dot product plus half an LSB of Q14, floor-shifted below.
    assign w_dot = 33'(r_p0) + 33'(r_p1) + 33'(r_p2) + 33'sd8192;

    assign w_cos2    = 38'(r_cos) * 38'(r_cos);
    assign w_eta_cos = 36'(w_eta_s2) * 36'(r_cos);

    always_comb begin
        w_sd3         = '0;
        w_sd3.eta_cos = w_eta_cos;
        w_sd3.ew_x    = r_ewx2;
        w_sd3.ew_y    = r_ewy2;
        w_sd3.ew_z    = r_ewz2;
        w_sd3.n_x     = r_nx2;
        w_sd3.n_y     = r_ny2;
        w_sd3.n_z     = r_nz2;
    end

    always_comb begin
        w_sd6     = r_sd5;
        w_sd6.tir = |r_sin2t[60:56];
    end

    // cos^2 is never negative, so its magnitude compares directly with 1.0.
    always_comb begin
        if (r_cos2 >= 38'sd268435456) begin
            w_sin2i = '0;
        end else begin
            w_sin2i = 29'(38'sd268435456 - r_cos2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0   <= 32'(i_wx) * 32'(i_nx);
        r_p1   <= 32'(i_wy) * 32'(i_ny);
        r_p2   <= 32'(i_wz) * 32'(i_nz);
        r_eta2 <= 32'(i_eta) * 32'(i_eta);
        r_eta1 <= i_eta;
        r_ewx1 <= 33'(w_eta_s1) * 33'(i_wx);
        r_ewy1 <= 33'(w_eta_s1) * 33'(i_wy);
        r_ewz1 <= 33'(w_eta_s1) * 33'(i_wz);
        r_nx1  <= i_nx;
        r_ny1  <= i_ny;
        r_nz1  <= i_nz;

        r_cos    <= w_dot[32:14];
        r_eta2_2 <= r_eta2;
        r_eta2s  <= r_eta1;
        r_ewx2   <= r_ewx1;
        r_ewy2   <= r_ewy1;
        r_ewz2   <= r_ewz1;
        r_nx2    <= r_nx1;
        r_ny2    <= r_ny1;
        r_nz2    <= r_nz1;

        r_cos2   <= w_cos2;
        r_eta2_3 <= r_eta2_2;
        r_sd3    <= w_sd3;

        r_sin2i  <= w_sin2i;
        r_eta2_4 <= r_eta2_3;
        r_sd4    <= r_sd3;

        r_sin2t  <= 61'(r_eta2_4) * 61'(r_sin2i);
        r_sd5    <= r_sd4;

        r_rad      <= (rv_pkg::RadW'(1) << 56) - r_sin2t[rv_pkg::RadW-1:0];
        r_sd6      <= w_sd6;
    end

    assign o_vld  = r_v6;
    assign o_rad  = r_rad;
    assign o_side = r_sd6;

endmodule

FILE: hw/rtl/rv_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side data
// carried alongside. Depends on rv_pkg.

module rv_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [rv_pkg::RadW-1:0]         i_rad,
    input  rv_pkg::t_side                   i_side,
    output logic                            o_vld,
    output logic [rv_pkg::SqrtBits-1:0]     o_root,
    output rv_pkg::t_side                   o_side
);

    logic                          r_vld  [rv_pkg::SqrtBits];
    logic [rv_pkg::RadW-1:0]       r_rem  [rv_pkg::SqrtBits];
    logic [rv_pkg::SqrtBits-1:0]   r_root [rv_pkg::SqrtBits];
    rv_pkg::t_side                 r_sd   [rv_pkg::SqrtBits];

    for (genvar s = 0; s < rv_pkg::SqrtBits; s++) begin : g_stage
        localparam int B = rv_pkg::SqrtBits - 1 - s;

        logic                          w_vld_in;
        logic [rv_pkg::RadW-1:0]       w_rem_in;
        logic [rv_pkg::SqrtBits-1:0]   w_root_in;
        rv_pkg::t_side                 w_sd_in;
        logic [rv_pkg::TrialW-1:0]     w_trial;
        logic                          w_take;
        logic [rv_pkg::RadW-1:0]       n_rem;
        logic [rv_pkg::SqrtBits-1:0]   n_root;

        if (s == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_rad;
            assign w_root_in = '0;
            assign w_sd_in   = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_sd_in   = r_sd[s-1];
        end

        // The remainder holds v - q^2; adding bit B to q raises q^2 by
        // q*2^(B+1) + 2^(2B).
        always_comb begin
            w_trial = (rv_pkg::TrialW'(w_root_in) << (B + 1))
                    + (rv_pkg::TrialW'(1) << (2 * B));
            w_take  = {2'b00, w_rem_in} >= w_trial;
            if (w_take) begin
                n_rem  = w_rem_in - w_trial[rv_pkg::RadW-1:0];
                n_root = w_root_in | (rv_pkg::SqrtBits'(1) << B);
            end else begin
                n_rem  = w_rem_in;
                n_root = w_root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_sd[s]   <= w_sd_in;
        end
    end

    assign o_vld  = r_vld[rv_pkg::SqrtBits-1];
    assign o_root = r_root[rv_pkg::SqrtBits-1];
    assign o_side = r_sd[rv_pkg::SqrtBits-1];

endmodule

FILE: hw/rtl/rv_back.sv
// Back stages of the refraction core: the normal scale k, the component
// products, rounding and saturation. Depends on rv_pkg.

module rv_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [rv_pkg::SqrtBits-1:0]      i_root,
    input  rv_pkg::t_side                    i_side,
    output logic                             o_vld,
    output logic                             o_refracted,
    output logic signed [rv_pkg::DataW-1:0]  o_x,
    output logic signed [rv_pkg::DataW-1:0]  o_y,
    output logic signed [rv_pkg::DataW-1:0]  o_z
);

    logic               r_v1;
    logic signed [36:0] r_k;
    rv_pkg::t_side      r_sd1;

    logic               r_v2;
    logic signed [52:0] r_knx, r_kny, r_knz;
    logic signed [32:0] r_ewx, r_ewy, r_ewz;
    logic               r_tir2;

    logic               r_v3;
    logic               r_refr;
    logic signed [15:0] r_x, r_y, r_z;

    logic signed [36:0] w_k;
    logic signed [15:0] w_x, w_y, w_z;

    // Q42 sum rounded to Q14, saturated to the signed 16-bit range.
    function automatic logic signed [15:0] round_sat(
        input logic signed [52:0] kn,
        input logic signed [32:0] ew
    );
        logic signed [53:0] acc;
        logic signed [25:0] q;
        acc = 54'(kn) - (54'(ew) <<< 14) + 54'sd134217728;
        q   = acc[53:28];
        if (q > 26'sd32767) begin
            round_sat = 16'sh7FFF;
        end else if (q < -26'sd32768) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[15:0];
        end
    endfunction

    assign w_k = 37'(i_side.eta_cos) - $signed(37'(i_root));

    assign w_x = round_sat(r_knx, r_ewx);
    assign w_y = round_sat(r_kny, r_ewy);
    assign w_z = round_sat(r_knz, r_ewz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= w_k;
        r_sd1 <= i_side;

        r_knx  <= 53'(r_k) * 53'(r_sd1.n_x);
        r_kny  <= 53'(r_k) * 53'(r_sd1.n_y);
        r_knz  <= 53'(r_k) * 53'(r_sd1.n_z);
        r_ewx  <= r_sd1.ew_x;
        r_ewy  <= r_sd1.ew_y;
        r_ewz  <= r_sd1.ew_z;
        r_tir2 <= r_sd1.tir;

        // Total internal reflection gives a zero vector.
        r_refr <= ~r_tir2;
        r_x    <= r_tir2 ? '0 : w_x;
        r_y    <= r_tir2 ? '0 : w_y;
        r_z    <= r_tir2 ? '0 : w_z;
    end

    assign o_vld       = r_v3;
    assign o_refracted = r_refr;
    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_z         = r_z;

endmodule

FILE: hw/rtl/refraction_vector_core.sv
// Top level of the refraction direction core.
// Instantiates rv_front, rv_sqrt and rv_back; depends on rv_pkg.

// The core takes one ray per clock: a beat is accepted whenever start is high
// and busy is low, and busy is high only while reset is held. Each beat gives
// one result, marked by o_valid for a single cycle; the result is not held,
// so the receiver must take it in that cycle. The result passes through the
// 29-stage square root pipeline (one root bit per stage), with six stages in
// front of it for the dot product and sin2t and three behind it for the final
// products, rounding and saturation.

module refraction_vector_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [rv_pkg::DataW-1:0] i_in_x,
    input  logic signed [rv_pkg::DataW-1:0] i_in_y,
    input  logic signed [rv_pkg::DataW-1:0] i_in_z,
    input  logic signed [rv_pkg::DataW-1:0] i_norm_x,
    input  logic signed [rv_pkg::DataW-1:0] i_norm_y,
    input  logic signed [rv_pkg::DataW-1:0] i_norm_z,
    input  logic        [rv_pkg::DataW-1:0] i_index_ratio,
    output logic                            o_valid,
    output logic                            o_refracted,
    output logic signed [rv_pkg::DataW-1:0] o_out_x,
    output logic signed [rv_pkg::DataW-1:0] o_out_y,
    output logic signed [rv_pkg::DataW-1:0] o_out_z
);

    logic                          w_accept;
    logic                          w_f_vld;
    logic [rv_pkg::RadW-1:0]       w_f_rad;
    rv_pkg::t_side                 w_f_side;
    logic                          w_s_vld;
    logic [rv_pkg::SqrtBits-1:0]   w_s_root;
    rv_pkg::t_side                 w_s_side;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    rv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_wx    (i_in_x),
        .i_wy    (i_in_y),
        .i_wz    (i_in_z),
        .i_nx    (i_norm_x),
        .i_ny    (i_norm_y),
        .i_nz    (i_norm_z),
        .i_eta   (i_index_ratio),
        .o_vld   (w_f_vld),
        .o_rad   (w_f_rad),
        .o_side  (w_f_side)
    );

    rv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_rad   (w_f_rad),
        .i_side  (w_f_side),
        .o_vld   (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    rv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_s_vld),
        .i_root      (w_s_root),
        .i_side      (w_s_side),
        .o_vld       (o_valid),
        .o_refracted (o_refracted),
        .o_x         (o_out_x),
        .o_y         (o_out_y),
        .o_z         (o_out_z)
    );

endmodule

FILE: hw/rtl/rv_checker.sv
// Port-level checks for refraction_vector_core, attached by bind.
// Depends on rv_pkg for the pipeline latency.

module rv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic        [rv_pkg::DataW-1:0] i_index_ratio,
    input logic                            o_valid,
    input logic                            o_refracted,
    input logic signed [rv_pkg::DataW-1:0] o_out_x,
    input logic signed [rv_pkg::DataW-1:0] o_out_y,
    input logic signed [rv_pkg::DataW-1:0] o_out_z
);

    // Every accepted beat comes out after the fixed latency.
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rv_pkg::Latency) o_valid)
        else $error("accepted beat produced no result");

    // No result appears without a beat accepted one latency earlier.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, rv_pkg::Latency))
        else $error("result without a matching input beat");

    // A zero index ratio can never reflect totally.
    a_zero_eta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_index_ratio == '0) |->
            ##(rv_pkg::Latency) (o_valid && o_refracted))
        else $error("zero index ratio reported total reflection");

    // Total internal reflection carries a zero vector.
    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_refracted) |->
            (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("reflected result has a nonzero direction");

endmodule

bind refraction_vector_core rv_checker u_rv_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for refraction_vector_core (Snell refraction direction).
// Drives ray beats from a queue, predicts each result in fixed point and checks
// every strobed result in order; depends on rv_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int  RandomRays = 450;
    localparam int  QuietTail  = 60;
    localparam int  CycleLimit = 200000;
    localparam int  DrainWait  = rv_pkg::Latency + 10;

    localparam longint OneQ28  = 64'sd1 << 28;
    localparam longint OneQ56  = 64'sd1 << 56;
    localparam longint HalfQ14 = 64'sd1 << 13;
    localparam longint HalfQ28 = 64'sd1 << 27;

    typedef struct {
        logic signed [15:0] wx, wy, wz;
        logic signed [15:0] nx, ny, nz;
        logic        [15:0] eta;
    } t_ray;

    typedef struct {
        logic               refracted;
        logic signed [15:0] x, y, z;
    } t_dir;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic signed [15:0] i_in_x   = '0;
    logic signed [15:0] i_in_y   = '0;
    logic signed [15:0] i_in_z   = '0;
    logic signed [15:0] i_norm_x = '0;
    logic signed [15:0] i_norm_y = '0;
    logic signed [15:0] i_norm_z = '0;
    logic        [15:0] i_index_ratio = '0;
    logic        busy;
    logic        o_valid;
    logic        o_refracted;
    logic signed [15:0] o_out_x, o_out_y, o_out_z;

    t_ray pending_rays[$];
    t_dir expected_dirs[$];
    int   fail_count  = 0;
    int   cycle_count = 0;
    bit   took_beat   = 1'b0;
    int   gap_left    = 0;
    int   quiet_left  = 0;

    refraction_vector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_in_x        (i_in_x),
        .i_in_y        (i_in_y),
        .i_in_z        (i_in_z),
        .i_norm_x      (i_norm_x),
        .i_norm_y      (i_norm_y),
        .i_norm_z      (i_norm_z),
        .i_index_ratio (i_index_ratio),
        .o_valid       (o_valid),
        .o_refracted   (o_refracted),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint floor_root(longint v);
        longint res;
        longint bitv;
        res  = 0;
        bitv = 64'sd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp_q14(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // Transmitted direction of one ray; all products are exact in 64 bits.
    function automatic t_dir refract_dir(t_ray r);
        longint w[3];
        longint n[3];
        longint eta, dotp, cosq, sin2i, sin2t, cost, k, acc;
        t_dir   res;
        eta  = r.eta;
        w[0] = r.wx; w[1] = r.wy; w[2] = r.wz;
        n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
        dotp = w[0] * n[0] + w[1] * n[1] + w[2] * n[2];
        cosq = (dotp + HalfQ14) >>> 14;
        sin2i = OneQ28 - cosq * cosq;
        if (sin2i < 0)
            sin2i = 0;
        sin2t = eta * eta * sin2i;
        res = '{1'b0, 16'sd0, 16'sd0, 16'sd0};
        if (sin2t < OneQ56) begin
            cost = floor_root(OneQ56 - sin2t);
            k    = eta * cosq - cost;
            res.refracted = 1'b1;
            acc   = k * n[0] - eta * w[0] * 16384;
            res.x = clamp_q14((acc + HalfQ28) >>> 28);
            acc   = k * n[1] - eta * w[1] * 16384;
            res.y = clamp_q14((acc + HalfQ28) >>> 28);
            acc   = k * n[2] - eta * w[2] * 16384;
            res.z = clamp_q14((acc + HalfQ28) >>> 28);
        end
        return res;
    endfunction

    task automatic add_ray(int wx, int wy, int wz, int nx, int ny, int nz, int eta);
        t_ray r;
        r.wx = 16'(wx); r.wy = 16'(wy); r.wz = 16'(wz);
        r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
        r.eta = 16'(eta);
        pending_rays.insert(pending_rays.size(), r);
    endtask

    // Random direction of length close to 1.0 in Q2.14.
    task automatic unit_vec(output int x, output int y, output int z);
        real a, b, c, len;
        a = real'(int'($urandom_range(0, 2000)) - 1000);
        b = real'(int'($urandom_range(0, 2000)) - 1000);
        c = real'(int'($urandom_range(0, 2000)) - 1000);
        len = $sqrt(a * a + b * b + c * c);
        if (len < 1.0) begin
            a   = 1.0;
            len = 1.0;
        end
        x = $rtoi(a / len * 16384.0);
        y = $rtoi(b / len * 16384.0);
        z = $rtoi(c / len * 16384.0);
    endtask

    task automatic check_field(string label, logic signed [16:0] want,
                               logic signed [16:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // Results are checked before the new beat is queued; the latency keeps them apart.
    always @(posedge i_clk) begin
        t_dir want;
        t_ray seen;
        cycle_count++;
        took_beat = 1'b0;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_dirs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual refracted=%0d x=%0d",
                         $time, o_refracted, o_out_x);
                fail_count++;
            end else begin
                want = expected_dirs.pop_front();
                check_field("refracted", 17'(want.refracted), 17'(o_refracted));
                check_field("out_x", 17'(want.x), 17'(o_out_x));
                check_field("out_y", 17'(want.y), 17'(o_out_y));
                check_field("out_z", 17'(want.z), 17'(o_out_z));
            end
        end
        if (i_rst_n && start && !busy) begin
            seen.wx = i_in_x;   seen.wy = i_in_y;   seen.wz = i_in_z;
            seen.nx = i_norm_x; seen.ny = i_norm_y; seen.nz = i_norm_z;
            seen.eta = i_index_ratio;
            expected_dirs.insert(expected_dirs.size(), refract_dir(seen));
            void'(pending_rays.pop_front());
            took_beat = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        logic nxt_start;
        nxt_start = 1'b0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (start && !took_beat) begin
            nxt_start = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (pending_rays.size() == 0) begin
            nxt_start = 1'b0;
        end else if (pending_rays.size() > QuietTail && quiet_left == 0 &&
                     $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
        end else begin
            nxt_start = 1'b1;
            i_in_x        <= pending_rays[0].wx;
            i_in_y        <= pending_rays[0].wy;
            i_in_z        <= pending_rays[0].wz;
            i_norm_x      <= pending_rays[0].nx;
            i_norm_y      <= pending_rays[0].ny;
            i_norm_z      <= pending_rays[0].nz;
            i_index_ratio <= pending_rays[0].eta;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 15) == 0)
                quiet_left = $urandom_range(20, 60);
        end
        start <= nxt_start;
    end

    initial begin
        int sel, wx, wy, wz, nx, ny, nz, eta;

        // Normal incidence, the exact critical angle and either side of it.
        add_ray(0, 0, 16384, 0, 0, 16384, 16384);
        add_ray(16384, 0, 0, 0, 0, 16384, 16384);
        add_ray(16384, 0, 0, 0, 0, 16384, 16383);
        add_ray(16384, 0, 0, 0, 0, 16384, 24576);
        add_ray(16384, 0, 0, 0, 0, 16384, 8192);
        add_ray(16384, 0, 0, 0, 0, 16384, 1);
        add_ray(11585, 0, 11585, 0, 0, 16384, 10923);
        add_ray(11585, 0, 11585, 0, 0, 16384, 24576);
        add_ray(-11585, 0, 11585, 0, 0, -16384, 12000);
        add_ray(0, 16384, 0, 0, -16384, 0, 20000);
        // A zero ratio gives the negated normal, saturated at the high corner.
        add_ray(1234, -5678, 9999, 0, 0, 16384, 0);
        add_ray(100, 200, 300, -32768, -32768, -32768, 0);
        add_ray(0, 0, 0, 0, 0, 0, 0);
        add_ray(0, 0, 0, 0, 0, 0, 65535);
        // Out-of-range vectors drive cos past 1.0, which clamps sin2i.
        add_ray(32767, 0, 0, 32767, 0, 0, 16384);
        add_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
        add_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535);
        add_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535);
        add_ray(-32768, 32767, -32768, 32767, -32768, 32767, 32768);
        add_ray(0, 0, 16384, 0, 0, 16384, 65535);

        for (int i = 0; i < RandomRays; i++) begin
            sel = $urandom_range(0, 9);
            unit_vec(wx, wy, wz);
            unit_vec(nx, ny, nz);
            eta = $urandom_range(8000, 33000);
            if (sel == 5) begin
                eta = $urandom_range(0, 65535);
            end else if (sel == 6) begin
                eta = 16384 + int'($urandom_range(0, 64)) - 32;
                wx  = nx + int'($urandom_range(0, 400)) - 200;
                wy  = ny + int'($urandom_range(0, 400)) - 200;
                wz  = nz + int'($urandom_range(0, 400)) - 200;
            end else if (sel >= 7) begin
                wx  = $urandom; wy = $urandom; wz = $urandom;
                nx  = $urandom; ny = $urandom; nz = $urandom;
                eta = $urandom;
            end
            add_ray(wx, wy, wz, nx, ny, nz, eta);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_rays.size() > 0 || expected_dirs.size() > 0) &&
               cycle_count < CycleLimit)
            @(posedge i_clk);

        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
        end else begin
            repeat (DrainWait) @(posedge i_clk);
            if (fail_count == 0 && expected_dirs.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
